[rtl/json_string_unescape_utf8_core_macros.svh]
// Assertion macros shared by the RTL; the user module provides i_clk and i_rst_n.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define JSU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/jsu_pkg.sv]
package jsu_pkg;

    // Special bytes of the string text
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_LOW_U  = 8'h75;

    // Surrogate ranges
    localparam logic [15:0] HIGH_SUR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_SUR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SUR_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // Hex digits that complete one unit
    localparam logic [2:0] HEX_DIGITS = 3'd4;

    // Decoder modes
    typedef enum logic [5:0] {
        MODE_PLAIN    = 6'b000001,
        MODE_ESC      = 6'b000010,
        MODE_HEX1     = 6'b000100,
        MODE_HIGH     = 6'b001000,
        MODE_HIGH_ESC = 6'b010000,
        MODE_HEX2     = 6'b100000
    } t_mode;

    // UTF-8 sequence, byte 0 goes out first
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } t_utf8;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) v = 4'(c - 8'h30);
        else if (c inside {[8'h61:8'h66]}) v = 4'(c - 8'h57);
        else if (c inside {[8'h41:8'h46]}) v = 4'(c - 8'h37);
        return v;
    endfunction

    function automatic logic [7:0] escape_char(input logic [7:0] e);
        logic [7:0] r;
        case (e)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = e;
        endcase
        return r;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 u;
        u.b = '0;
        if (cp <= 21'h7F) begin
            u.len  = 3'd1;
            u.b[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            u.len  = 3'd2;
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            u.len  = 3'd3;
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
        end else begin
            u.len  = 3'd4;
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

[rtl/jsu_if.sv]
// Raw string text, one byte per transfer
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_last;

    modport source (output valid, in_byte, text_last, input ready);
    modport sink   (input valid, in_byte, text_last, output ready);
endinterface

// Decoded UTF-8 bytes and end markers, one result per transfer
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       ended_by_quote;
    logic       last_of_run;

    modport source (output valid, out_byte, byte_valid, string_end, ended_by_quote,
                    last_of_run, input ready);
    modport sink   (input valid, out_byte, byte_valid, string_end, ended_by_quote,
                    last_of_run, output ready);
endinterface

[rtl/json_string_unescape_utf8_core.sv]
// Channel | Dir | Payload                                                     | Transfer
// i_in    | in  | in_byte[7:0], text_last                                     | valid & ready
// o_out   | out | out_byte[7:0], byte_valid, string_end, ended_by_quote,      | valid & ready
//         |     | last_of_run                                                 |
//
// An accepted byte is held in the input register, then is decoded in one pass
// into a result buffer of up to four results that drains one result per output transfer.
// Rate: one byte per cycle while each byte gives at most one result and o_out is ready;
// a byte with more results holds the next byte in the input register until they drain.
// Reset (i_rst_n low, synchronous) empties both registers and returns to plain mode.
// An output stall holds the current result; bytes that give no result still pass.
`include "json_string_unescape_utf8_core_macros.svh"

module json_string_unescape_utf8_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    // Input register
    logic       r_iv;
    logic [7:0] r_ibyte;
    logic       r_ilast;

    // Decoder state
    jsu_pkg::t_mode r_mode, n_mode;
    logic [15:0]    r_acc, n_acc;
    logic [2:0]     r_cnt, n_cnt;
    logic [15:0]    r_high, n_high;

    // Result buffer
    logic            r_obusy;
    logic [3:0][7:0] r_ob;
    logic [1:0]      r_oidx;
    logic [1:0]      r_olast_idx;
    logic            r_obv;
    logic            r_oend;
    logic            r_oquote;

    // Decode signals
    logic            w_cp_v;
    logic [20:0]     w_cp;
    logic            w_b_v;
    logic [7:0]      w_b;
    logic            w_quote;
    logic            w_ended;
    logic [15:0]     w_gath;
    logic [2:0]      w_cnt_inc;
    jsu_pkg::t_utf8  w_enc;
    logic [2:0]      w_ncp;
    logic [2:0]      w_nbytes;
    logic [2:0]      w_nres;
    logic [3:0][7:0] w_buf;
    logic            w_ofree;
    logic            w_move;
    logic            w_olast;
    logic            w_clean;

    assign w_gath    = {r_acc[11:0], jsu_pkg::hex_val(r_ibyte)};
    assign w_cnt_inc = r_cnt + 3'd1;

    // Decode the held byte against the current mode
    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_high  = r_high;
        w_cp_v  = 1'b0;
        w_cp    = '0;
        w_b_v   = 1'b0;
        w_b     = '0;
        w_quote = 1'b0;
        case (r_mode)
            jsu_pkg::MODE_ESC: begin
                if (r_ibyte == jsu_pkg::C_LOW_U) begin
                    n_mode = jsu_pkg::MODE_HEX1;
                    n_acc  = '0;
                    n_cnt  = '0;
                end else begin
                    w_b_v  = 1'b1;
                    w_b    = jsu_pkg::escape_char(r_ibyte);
                    n_mode = jsu_pkg::MODE_PLAIN;
                end
            end
            jsu_pkg::MODE_HEX1: begin
                n_acc = w_gath;
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= jsu_pkg::HEX_DIGITS) begin
                    if (w_gath inside {[jsu_pkg::HIGH_SUR_MIN:jsu_pkg::HIGH_SUR_MAX]}) begin
                        n_high = w_gath;
                        n_mode = jsu_pkg::MODE_HIGH;
                    end else begin
                        w_cp_v = 1'b1;
                        w_cp   = {5'd0, w_gath};
                        n_mode = jsu_pkg::MODE_PLAIN;
                    end
                    n_acc = '0;
                    n_cnt = '0;
                end
            end
            jsu_pkg::MODE_HIGH: begin
                if (r_ibyte == jsu_pkg::C_BSLASH) begin
                    n_mode = jsu_pkg::MODE_HIGH_ESC;
                end else begin
                    w_cp_v = 1'b1;
                    w_cp   = {5'd0, r_high};
                    n_mode = jsu_pkg::MODE_PLAIN;
                    if (r_ibyte == jsu_pkg::C_QUOTE) begin
                        w_quote = 1'b1;
                    end else begin
                        w_b_v = 1'b1;
                        w_b   = r_ibyte;
                    end
                end
            end
            jsu_pkg::MODE_HIGH_ESC: begin
                if (r_ibyte == jsu_pkg::C_LOW_U) begin
                    n_mode = jsu_pkg::MODE_HEX2;
                    n_acc  = '0;
                    n_cnt  = '0;
                end else begin
                    w_cp_v = 1'b1;
                    w_cp   = {5'd0, r_high};
                    w_b_v  = 1'b1;
                    w_b    = jsu_pkg::escape_char(r_ibyte);
                    n_mode = jsu_pkg::MODE_PLAIN;
                end
            end
            jsu_pkg::MODE_HEX2: begin
                n_acc = w_gath;
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= jsu_pkg::HEX_DIGITS) begin
                    w_cp_v = 1'b1;
                    if (w_gath inside {[jsu_pkg::LOW_SUR_MIN:jsu_pkg::LOW_SUR_MAX]}) begin
                        w_cp = jsu_pkg::SUPP_BASE + {1'b0, r_high[9:0], w_gath[9:0]};
                    end else begin
                        w_cp = {5'd0, r_high};
                    end
                    n_mode = jsu_pkg::MODE_PLAIN;
                    n_acc  = '0;
                    n_cnt  = '0;
                end
            end
            default: begin
                n_mode = jsu_pkg::MODE_PLAIN;
                if (r_ibyte == jsu_pkg::C_QUOTE) begin
                    w_quote = 1'b1;
                end else if (r_ibyte == jsu_pkg::C_BSLASH) begin
                    n_mode = jsu_pkg::MODE_ESC;
                end else begin
                    w_b_v = 1'b1;
                    w_b   = r_ibyte;
                end
            end
        endcase

        // End of text: flush a partial unit or a pending high surrogate
        w_ended = w_quote || r_ilast;
        if (!w_quote && r_ilast) begin
            if (n_mode == jsu_pkg::MODE_HEX1) begin
                w_cp_v = 1'b1;
                w_cp   = {5'd0, n_acc};
            end else if (n_mode inside {jsu_pkg::MODE_HIGH, jsu_pkg::MODE_HIGH_ESC,
                                        jsu_pkg::MODE_HEX2}) begin
                w_cp_v = 1'b1;
                w_cp   = {5'd0, n_high};
            end
        end
        if (w_ended) begin
            n_mode = jsu_pkg::MODE_PLAIN;
            n_acc  = '0;
            n_cnt  = '0;
            n_high = '0;
        end
    end

    // Lay out the code point bytes, then the single byte
    assign w_enc    = jsu_pkg::utf8_encode(w_cp);
    assign w_ncp    = w_cp_v ? w_enc.len : 3'd0;
    assign w_nbytes = w_ncp + {2'd0, w_b_v};
    assign w_nres   = (w_nbytes == 3'd0 && w_ended) ? 3'd1 : w_nbytes;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_buf[k] = (3'(k) < w_ncp) ? w_enc.b[k] : w_b;
        end
    end

    // Handshake between the two registers
    assign w_olast  = (r_oidx == r_olast_idx);
    assign w_ofree  = !r_obusy || (o_out.ready && w_olast);
    assign w_move   = r_iv && (w_nres == 3'd0 || w_ofree);
    assign i_in.ready = !r_iv || w_move;

    // Capture an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_iv <= 1'b1;
        end else if (w_move) begin
            r_iv <= 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            r_ibyte <= i_in.in_byte;
            r_ilast <= i_in.text_last;
        end
    end

    // Advance the decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::MODE_PLAIN;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_high <= '0;
        end else if (w_move) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_high <= n_high;
        end
    end

    // Load the result buffer, drain one result per output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obusy <= 1'b0;
            r_oidx  <= '0;
        end else if (w_move && w_nres != 3'd0) begin
            r_obusy <= 1'b1;
            r_oidx  <= '0;
        end else if (r_obusy && o_out.ready) begin
            if (w_olast) begin
                r_obusy <= 1'b0;
            end else begin
                r_oidx <= r_oidx + 2'd1;
            end
        end
        if (w_move && w_nres != 3'd0) begin
            r_ob        <= w_buf;
            r_olast_idx <= 2'(w_nres - 3'd1);
            r_obv       <= (w_nbytes != 3'd0);
            r_oend      <= w_ended;
            r_oquote    <= w_quote;
        end
    end

    assign o_out.valid          = r_obusy;
    assign o_out.out_byte       = r_ob[r_oidx];
    assign o_out.byte_valid     = r_obv;
    assign o_out.last_of_run    = w_olast;
    assign o_out.string_end     = w_olast && r_oend;
    assign o_out.ended_by_quote = w_olast && r_oend && r_oquote;

    // Decoder back in plain mode with nothing pending
    assign w_clean = (r_mode == jsu_pkg::MODE_PLAIN) && (r_acc == '0) && (r_cnt == '0) &&
                     (r_high == '0);

    // A stalled result keeps its place in the buffer
    `JSU_ASSERT_NEXT(a_stall_holds, r_obusy && !o_out.ready, r_obusy && $stable(r_oidx), "moved")
    // An end-only marker is a single result that ends the string
    `JSU_ASSERT_SAME(a_marker_single, r_obusy && !r_obv, r_olast_idx == 2'd0 && r_oend, "marker")
    // The end of a string leaves the decoder clean
    `JSU_ASSERT_NEXT(a_end_clears, w_move && w_ended, w_clean, "state kept after end")
    // A held byte that cannot move blocks new input
    `JSU_ASSERT_SAME(a_in_blocked, r_iv && !w_move, !i_in.ready, "input taken while full")

endmodule
